/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL modules of the LFU cache table; lfu_seq uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define ASSERT_CHK(label, prop, msg)
`define ASSERT_NEVER(label, prop, msg)
`endif

`endif

/* hw/rtl/lfu_pkg.sv */
// Types and constants shared by the LFU cache table modules.
package lfu_pkg;

  localparam int unsigned CAP_W = 5;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic                    req_type;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } lfu_req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } lfu_result_t;

endpackage

/* hw/rtl/lfu_mem.sv */
// Entry memory: one write port, one read port, registered read data.
module lfu_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 84,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/lfu_seq.sv */
// Request sequencer: key/victim scan pass, then, for a get hit or a put at nonzero capacity, rank/count update pass.
`include "assert_macros.svh"

module lfu_seq #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned COUNT_BITS  = 16,
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned ROW_W = 64 + COUNT_BITS + IDX_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CNT_W-1:0]      cap_i,
  input  logic                  clr_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  lfu_pkg::lfu_req_t     req_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output lfu_pkg::lfu_result_t  res_o,
  output logic                  mem_re_o,
  output logic [IDX_W-1:0]      mem_raddr_o,
  input  logic [ROW_W-1:0]      mem_rdata_i,
  output logic                  mem_we_o,
  output logic [IDX_W-1:0]      mem_waddr_o,
  output logic [ROW_W-1:0]      mem_wdata_o
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPD,
    S_DONE
  } state_e;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

  state_e                 state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]       held_q;

  lfu_req_t               req_q;
  lfu_result_t            res_q;
  logic                   found_q;
  logic [IDX_W-1:0]       hit_idx_q;
  logic [IDX_W-1:0]       hit_rank_q;
  logic [VAL_W-1:0]       hit_val_q;
  logic                   vic_have_q;
  logic [IDX_W-1:0]       vic_idx_q;
  logic [COUNT_BITS-1:0]  vic_cnt_q;
  logic [IDX_W-1:0]       vic_rank_q;
  logic [KEY_W-1:0]       vic_key_q;
  logic                   free_have_q;
  logic [IDX_W-1:0]       free_idx_q;
  logic [IDX_W-1:0]       tgt_q;
  logic [IDX_W-1:0]       rref_q;
  logic                   all_q;
  logic                   ins_q;
  logic                   keep_q;

  logic [CNT_W-1:0]       cnt_m1;
  logic [IDX_W-1:0]       pidx;
  logic                   p_valid;
  logic [KEY_W-1:0]       r_key;
  logic [VAL_W-1:0]       r_val;
  logic [COUNT_BITS-1:0]  r_cnt;
  logic [IDX_W-1:0]       r_rank;
  logic                   is_put;
  logic                   full;

  logic                   dec_upd;
  logic                   dec_ins;
  logic                   dec_all;
  logic                   dec_keep;
  logic                   dec_set_valid;
  logic [IDX_W-1:0]       dec_tgt;
  logic [IDX_W-1:0]       dec_rref;
  lfu_result_t            dec_res;

  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign pidx    = cnt_m1[IDX_W-1:0];
  assign p_valid = valid_q[pidx];
  assign r_key   = mem_rdata_i[KEY_W-1:0];
  assign r_val   = mem_rdata_i[KEY_W +: VAL_W];
  assign r_cnt   = mem_rdata_i[KEY_W+VAL_W +: COUNT_BITS];
  assign r_rank  = mem_rdata_i[KEY_W+VAL_W+COUNT_BITS +: IDX_W];
  assign is_put  = (req_q.req_type == REQ_PUT);
  assign full    = (held_q >= cap_i);

  assign req_ready_o = (state_q == S_IDLE) && !clr_i;
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  assign mem_re_o    = ((state_q == S_SCAN) || (state_q == S_UPD)) && (cnt_q < LAST);
  assign mem_raddr_o = cnt_q[IDX_W-1:0];
  assign mem_we_o    = (state_q == S_UPD) && (cnt_q != '0);
  assign mem_waddr_o = pidx;

  always_comb begin
    dec_upd       = 1'b0;
    dec_ins       = 1'b0;
    dec_all       = 1'b0;
    dec_keep      = 1'b0;
    dec_set_valid = 1'b0;
    dec_tgt       = hit_idx_q;
    dec_rref      = hit_rank_q;
    dec_res       = '0;
    if (!is_put) begin
      if (found_q) begin
        dec_upd             = 1'b1;
        dec_keep            = 1'b1;
        dec_res.hit         = 1'b1;
        dec_res.read_value  = hit_val_q;
      end else begin
        dec_res.read_value  = MISS_VALUE;
      end
    end else if (cap_i != '0) begin
      dec_upd = 1'b1;
      if (found_q) begin
        dec_res.hit = 1'b1;
      end else if (full && vic_have_q) begin
        dec_ins             = 1'b1;
        dec_tgt             = vic_idx_q;
        dec_rref            = vic_rank_q;
        dec_res.evicted     = 1'b1;
        dec_res.evicted_key = vic_key_q;
      end else begin
        dec_ins       = 1'b1;
        dec_all       = 1'b1;
        dec_set_valid = 1'b1;
        dec_tgt       = free_idx_q;
      end
    end
  end

  always_comb begin
    mem_wdata_o = mem_rdata_i;
    if (pidx == tgt_q) begin
      if (ins_q) begin
        mem_wdata_o = {IDX_W'(0), COUNT_BITS'(1), req_q.value, req_q.key};
      end else begin
        mem_wdata_o = {IDX_W'(0), (r_cnt == COUNT_SAT) ? r_cnt : r_cnt + COUNT_BITS'(1),
                       keep_q ? r_val : req_q.value, r_key};
      end
    end else if (p_valid && (all_q || (r_rank < rref_q))) begin
      mem_wdata_o = {r_rank + IDX_W'(1), r_cnt, r_val, r_key};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= '0;
      held_q  <= '0;
    end else if (clr_i) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= '0;
      held_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (req_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_q == LAST) begin
            state_q <= S_DECIDE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_DECIDE: begin
          state_q <= dec_upd ? S_UPD : S_DONE;
          if (dec_set_valid) begin
            valid_q[dec_tgt] <= 1'b1;
            held_q           <= held_q + CNT_W'(1);
          end
        end
        S_UPD: begin
          if (cnt_q == LAST) begin
            state_q <= S_DONE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && req_valid_i) begin
      req_q       <= req_i;
      found_q     <= 1'b0;
      vic_have_q  <= 1'b0;
      free_have_q <= 1'b0;
    end
    if ((state_q == S_SCAN) && (cnt_q != '0)) begin
      if (p_valid) begin
        if (r_key == req_q.key) begin
          found_q    <= 1'b1;
          hit_idx_q  <= pidx;
          hit_rank_q <= r_rank;
          hit_val_q  <= r_val;
        end
        if (!vic_have_q || (r_cnt < vic_cnt_q) ||
            ((r_cnt == vic_cnt_q) && (r_rank > vic_rank_q))) begin
          vic_have_q <= 1'b1;
          vic_idx_q  <= pidx;
          vic_cnt_q  <= r_cnt;
          vic_rank_q <= r_rank;
          vic_key_q  <= r_key;
        end
      end else if (!free_have_q && (CNT_W'(pidx) < cap_i)) begin
        free_have_q <= 1'b1;
        free_idx_q  <= pidx;
      end
    end
    if (state_q == S_DECIDE) begin
      tgt_q  <= dec_tgt;
      rref_q <= dec_rref;
      all_q  <= dec_all;
      ins_q  <= dec_ins;
      keep_q <= dec_keep;
      res_q  <= dec_res;
    end
  end

  `ASSERT_CHK(a_held_le_cap, held_q <= cap_i, "entry count exceeds capacity")
  `ASSERT_CHK(a_held_matches_valid, $countones(valid_q) == held_q,
              "entry count disagrees with valid bits")
  `ASSERT_NEVER(a_hit_and_evict, res_valid_o && res_o.hit && res_o.evicted,
                "result both hit and evicted")

endmodule

/* hw/rtl/lfu_cache_table_unit.sv */
// LFU cache table top level: stream ports, capacity register, output register.
// Flow: each request is scanned over all rows; get hits and puts at nonzero capacity then
//   rewrite the rows in an update pass, while get misses and puts at capacity zero skip it.
// Flow control: one request at a time; a new input beat is taken only once the previous
//   result has moved into the output register.
// Reset: capacity 16, store empty, no output beat pending. A capacity write empties it.
module lfu_cache_table_unit #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key, value
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // read_value, evicted_key
  output logic [1:0]  m_axis_tuser    // hit, evicted
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ROW_W = 64 + COUNT_BITS + IDX_W;
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_ENTRIES);

  logic [CAP_W-1:0] capacity_q;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_sat;
  logic [CNT_W-1:0] cap_eff;

  lfu_req_t         req;
  lfu_result_t      res;
  logic             res_valid;
  logic             res_ready;

  logic             m_valid_q;
  logic [63:0]      m_data_q;
  logic [1:0]       m_user_q;

  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ROW_W-1:0] mem_rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  assign cap_ext = CMP_W'(capacity_q);
  assign cap_sat = (cap_ext > MAX_EXT) ? MAX_EXT : cap_ext;
  assign cap_eff = cap_sat[CNT_W-1:0];

  assign req.req_type = s_axis_tuser;
  assign req.key      = s_axis_tdata[31:0];
  assign req.value    = s_axis_tdata[63:32];

  lfu_seq #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_i      (cap_eff),
    .clr_i      (cfg_valid_i),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata)
  );

  lfu_mem #(
    .DEPTH(MAX_ENTRIES),
    .WIDTH(ROW_W)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (mem_re),
    .rd_addr_i(mem_raddr),
    .rd_data_o(mem_rdata),
    .wr_en_i  (mem_we),
    .wr_addr_i(mem_waddr),
    .wr_data_i(mem_wdata)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= {res.evicted_key, res.read_value};
      m_user_q <= {res.evicted, res.hit};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
